### sv/watchdog_timer_with_feed_key_top_assert.svh
// ----------------------------------------------------------------------------
// Watchdog timer assertion macros
// Shared concurrent assertion forms for the watchdog timer RTL.
// ----------------------------------------------------------------------------
`ifndef WATCHDOG_TIMER_WITH_FEED_KEY_TOP_ASSERT_SVH
`define WATCHDOG_TIMER_WITH_FEED_KEY_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WDTFK_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define WDTFK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/wdtfk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchdog timer package
// Operation codes, register offsets, status codes and control bit positions.
// ----------------------------------------------------------------------------
package wdtfk_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_READ   = 2'd1,
		ST_BAD_KEY    = 2'd2,
		ST_CTRL_LOCKED = 2'd3
	} status_t;

	localparam logic [11:0] OFS_CTRL = 12'd0;
	localparam logic [11:0] OFS_LOAD = 12'd4;
	localparam logic [11:0] OFS_VAL  = 12'd8;
	localparam logic [11:0] OFS_SR   = 12'd12;
	localparam logic [11:0] OFS_KEY  = 12'd16;

	localparam int CTRL_EN    = 0;
	localparam int CTRL_INTEN = 1;
	localparam int CTRL_RSTEN = 2;
	localparam int CTRL_LOCK  = 3;

	localparam logic CFG_FEED_KEY = 1'b0;
	localparam logic CFG_LOCK_KEY = 1'b1;

	localparam logic [31:0] FEED_KEY_RST = 32'h5A5A_5A5A;
	localparam logic [31:0] LOCK_KEY_RST = 32'h1ACC_E551;
	localparam logic [31:0] COUNT_RST    = 32'h0000_FFFF;

endpackage

### sv/watchdog_timer_with_feed_key_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchdog timer with feed key and control lock
// Tick / register-access engine with a one-item input stage and result stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: a tick, a register
//   read or a register write (operation, offset, write_data). Every item
//   gives exactly one result item on the output channel (out_valid/out_ready)
//   with read_data, irq and access_status.
//   An accepted item waits in the input stage, where the register update
//   and result are formed, until the result register is free or drains;
//   the result then moves into the output register and out_valid rises,
//   and the result is taken when out_ready is high.
//   Throughput is one item per clock while out_ready stays high; in_ready
//   stays high while results flow and the control/count registers update.
//   When the receiver stalls, the held result stays put and one more item
//   waits in the input stage; in_ready drops only while both are full.
//   Configuration (feed_key, lock_key) is written via cfg_write_en, cfg_index,
//   cfg_data with the block idle; the user must ensure it, the block does not.
//   Reset (arst_n low) empties both stages, clears CTRL, timeout and armed,
//   sets LOAD and VAL to 0xffff and restores the default keys.
// ----------------------------------------------------------------------------
module watchdog_timer_with_feed_key_top #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        cfg_write_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [11:0] offset,
	input  logic [31:0] write_data,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic        irq,
	output logic [1:0]  access_status
);

	// ------------------------------------------------------------------
	// Configuration registers: the two key values
	// ------------------------------------------------------------------
	logic [31:0] feed_key_q;
	logic [31:0] lock_key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_key_q <= wdtfk_pkg::FEED_KEY_RST;
			lock_key_q <= wdtfk_pkg::LOCK_KEY_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				wdtfk_pkg::CFG_FEED_KEY: feed_key_q <= cfg_data;
				wdtfk_pkg::CFG_LOCK_KEY: lock_key_q <= cfg_data;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input stage: hold one item until the result stage can take it
	// ------------------------------------------------------------------
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [11:0] ofs_s1;
	logic [31:0] wdata_s1;
	logic        out_valid_s2;
	logic        advance;

	// advance the item in stage 1 when the result register is free or drains
	assign advance  = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= operation;
			ofs_s1   <= offset;
			wdata_s1 <= write_data;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog state
	// ------------------------------------------------------------------
	logic [3:0]             ctrl_q;
	logic [COUNT_WIDTH-1:0] reload_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   timeout_q;
	logic                   armed_q;

	logic [3:0]             ctrl_d;
	logic [COUNT_WIDTH-1:0] reload_d;
	logic [COUNT_WIDTH-1:0] count_d;
	logic                   timeout_d;
	logic                   armed_d;
	logic [31:0]            rdata_d;
	wdtfk_pkg::status_t     status_d;

	// widened views so the low 32 bits read back at any count width
	logic [63:0]            reload_wide;
	logic [63:0]            count_wide;
	logic [COUNT_WIDTH-1:0] wdata_cnt;

	assign reload_wide = 64'(reload_q);
	assign count_wide  = 64'(count_q);
	assign wdata_cnt   = COUNT_WIDTH'(wdata_s1);

	// ------------------------------------------------------------------
	// Item decode and next state
	// ------------------------------------------------------------------
	always_comb begin
		ctrl_d    = ctrl_q;
		reload_d  = reload_q;
		count_d   = count_q;
		timeout_d = timeout_q;
		armed_d   = armed_q;
		rdata_d   = '0;
		status_d  = wdtfk_pkg::ST_OK;

		unique case (wdtfk_pkg::op_t'(op_s1))
			wdtfk_pkg::OP_TICK: begin
				// count only while enabled and armed; reaching zero times out
				if (ctrl_q[wdtfk_pkg::CTRL_EN] && armed_q) begin
					if (count_q != '0) begin
						count_d = count_q - COUNT_WIDTH'(1);
					end
					if (count_q == '0 || count_q == COUNT_WIDTH'(1)) begin
						timeout_d = 1'b1;
						armed_d   = 1'b0;
					end
				end
			end
			wdtfk_pkg::OP_READ: begin
				unique case (ofs_s1)
					wdtfk_pkg::OFS_CTRL: rdata_d = {28'd0, ctrl_q};
					wdtfk_pkg::OFS_LOAD: rdata_d = reload_wide[31:0];
					wdtfk_pkg::OFS_VAL:  rdata_d = count_wide[31:0];
					wdtfk_pkg::OFS_SR:   rdata_d = {31'd0, timeout_q};
					default:             status_d = wdtfk_pkg::ST_BAD_READ;
				endcase
			end
			wdtfk_pkg::OP_WRITE: begin
				unique case (ofs_s1)
					wdtfk_pkg::OFS_CTRL: begin
						if (ctrl_q[wdtfk_pkg::CTRL_LOCK]) begin
							status_d = wdtfk_pkg::ST_CTRL_LOCKED;
						end else begin
							// an EN change arms or disarms, count untouched
							if (ctrl_q[wdtfk_pkg::CTRL_EN] != wdata_s1[wdtfk_pkg::CTRL_EN]) begin
								armed_d = wdata_s1[wdtfk_pkg::CTRL_EN];
							end
							ctrl_d = wdata_s1[3:0];
						end
					end
					wdtfk_pkg::OFS_LOAD: begin
						reload_d = wdata_cnt;
						if (!ctrl_q[wdtfk_pkg::CTRL_EN]) begin
							count_d = wdata_cnt;
						end
					end
					wdtfk_pkg::OFS_SR: begin
						if (wdata_s1[0]) begin
							timeout_d = 1'b0;
						end
					end
					wdtfk_pkg::OFS_KEY: begin
						// feed wins when both keys match
						priority if (wdata_s1 == feed_key_q) begin
							count_d   = reload_q;
							timeout_d = 1'b0;
							if (ctrl_q[wdtfk_pkg::CTRL_EN]) begin
								armed_d = 1'b1;
							end
						end else if (wdata_s1 == lock_key_q) begin
							ctrl_d[wdtfk_pkg::CTRL_LOCK] = 1'b1;
						end else begin
							status_d = wdtfk_pkg::ST_BAD_KEY;
						end
					end
					default: begin
						// writes to VAL and unlisted offsets drop silently
					end
				endcase
			end
			default: begin
				// unused operation code: no-op with ok status
			end
		endcase
	end

	// commit state only when the item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q    <= '0;
			reload_q  <= COUNT_WIDTH'(wdtfk_pkg::COUNT_RST);
			count_q   <= COUNT_WIDTH'(wdtfk_pkg::COUNT_RST);
			timeout_q <= 1'b0;
			armed_q   <= 1'b0;
		end else if (advance) begin
			ctrl_q    <= ctrl_d;
			reload_q  <= reload_d;
			count_q   <= count_d;
			timeout_q <= timeout_d;
			armed_q   <= armed_d;
		end
	end

	// ------------------------------------------------------------------
	// Result stage
	// ------------------------------------------------------------------
	logic [31:0] read_data_s2;
	logic        irq_s2;
	logic [1:0]  status_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_s2 <= rdata_d;
			irq_s2       <= timeout_d && ctrl_d[wdtfk_pkg::CTRL_INTEN];
			status_s2    <= status_d;
		end
	end

	assign out_valid     = out_valid_s2;
	assign read_data     = read_data_s2;
	assign irq           = irq_s2;
	assign access_status = status_s2;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
`include "watchdog_timer_with_feed_key_top_assert.svh"

	`WDTFK_ASSERT_SAME(a_armed_needs_en, armed_q, ctrl_q[wdtfk_pkg::CTRL_EN], "armed while disabled")
	`WDTFK_ASSERT_SAME(a_timeout_at_zero, $rose(timeout_q), count_q == '0, "timeout with nonzero count")
	`WDTFK_ASSERT_NEXT(a_lock_freezes_ctrl, ctrl_q[wdtfk_pkg::CTRL_LOCK], $stable(ctrl_q), "ctrl changed while locked")
	`WDTFK_ASSERT_NEXT(a_state_holds_idle, !advance, $stable(count_q) && $stable(ctrl_q), "state moved without an item")

endmodule

### tb/watchdog_timer_with_feed_key_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchdog timer with feed key testbench
// Drives ticks and register accesses through the item channel and predicts
// every response from a local copy of CTRL, LOAD, VAL, SR and the keys.
// Both channels idle and stall at random, and the key registers are swept
// through several settings, including the extremes and equal keys.
// ----------------------------------------------------------------------------
module watchdog_timer_with_feed_key_top_tb;

	// operation three is not in op_t; the block treats it as a no-op
	localparam logic [1:0] OP_NOP = 2'd3;
	// cycles without any handshake before the run is declared hung
	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		logic [31:0]        read_data;
		logic               irq;
		wdtfk_pkg::status_t status;
	} wdt_response_t;

	// Tracks the watchdog registers and holds the responses still owed.
	class wdt_scoreboard;
		logic [3:0]    ctrl;
		logic [31:0]   reload;
		logic [31:0]   count;
		logic          timeout;
		logic          armed;
		logic [31:0]   feed_key;
		logic [31:0]   lock_key;
		wdt_response_t due_responses[$];
		int            failures;
		int            seen;

		function new();
			ctrl     = '0;
			reload   = wdtfk_pkg::COUNT_RST;
			count    = wdtfk_pkg::COUNT_RST;
			timeout  = 1'b0;
			armed    = 1'b0;
			feed_key = wdtfk_pkg::FEED_KEY_RST;
			lock_key = wdtfk_pkg::LOCK_KEY_RST;
			failures = 0;
			seen     = 0;
		endfunction

		function void set_key(logic idx, logic [31:0] value);
			if (idx == wdtfk_pkg::CFG_FEED_KEY)
				feed_key = value;
			else
				lock_key = value;
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= 10)
				$display("mismatch: %s", msg);
		endfunction

		// Apply one accepted item to the register copy and queue its response.
		function void apply_access(logic [1:0] op, logic [11:0] ofs, logic [31:0] data);
			wdt_response_t r;
			r.read_data = '0;
			r.status    = wdtfk_pkg::ST_OK;
			case (op)
			wdtfk_pkg::OP_TICK: begin
				if (ctrl[wdtfk_pkg::CTRL_EN] && armed) begin
					if (count != 0)
						count = count - 1;
					if (count == 0) begin
						timeout = 1'b1;
						armed   = 1'b0;
					end
				end
			end
			wdtfk_pkg::OP_READ: begin
				case (ofs)
				wdtfk_pkg::OFS_CTRL: r.read_data = {28'd0, ctrl};
				wdtfk_pkg::OFS_LOAD: r.read_data = reload;
				wdtfk_pkg::OFS_VAL:  r.read_data = count;
				wdtfk_pkg::OFS_SR:   r.read_data = {31'd0, timeout};
				default:             r.status = wdtfk_pkg::ST_BAD_READ;
				endcase
			end
			wdtfk_pkg::OP_WRITE: begin
				case (ofs)
				wdtfk_pkg::OFS_CTRL: begin
					if (ctrl[wdtfk_pkg::CTRL_LOCK]) begin
						r.status = wdtfk_pkg::ST_CTRL_LOCKED;
					end else begin
						if (ctrl[wdtfk_pkg::CTRL_EN] != data[wdtfk_pkg::CTRL_EN])
							armed = data[wdtfk_pkg::CTRL_EN];
						ctrl = data[3:0];
					end
				end
				wdtfk_pkg::OFS_LOAD: begin
					if (!ctrl[wdtfk_pkg::CTRL_EN])
						count = data;
					reload = data;
				end
				wdtfk_pkg::OFS_SR: begin
					if (data[0])
						timeout = 1'b0;
				end
				wdtfk_pkg::OFS_KEY: begin
					if (data == feed_key) begin
						count   = reload;
						timeout = 1'b0;
						if (ctrl[wdtfk_pkg::CTRL_EN])
							armed = 1'b1;
					end else if (data == lock_key) begin
						ctrl[wdtfk_pkg::CTRL_LOCK] = 1'b1;
					end else begin
						r.status = wdtfk_pkg::ST_BAD_KEY;
					end
				end
				default: ;
				endcase
			end
			default: ;
			endcase
			r.irq = timeout & ctrl[wdtfk_pkg::CTRL_INTEN];
			due_responses.push_back(r);
		endfunction

		function void check_response(logic [31:0] rd, logic irq_level, logic [1:0] st);
			wdt_response_t want;
			seen++;
			if (due_responses.size() == 0) begin
				note_failure($sformatf("response %0d arrived with none outstanding", seen));
				return;
			end
			want = due_responses.pop_front();
			if (want.read_data !== rd)
				note_failure($sformatf("response %0d read_data: expected %h, got %h",
					seen, want.read_data, rd));
			if (want.irq !== irq_level)
				note_failure($sformatf("response %0d irq: expected %b, got %b",
					seen, want.irq, irq_level));
			if (want.status !== st)
				note_failure($sformatf("response %0d access_status: expected %0d, got %0d",
					seen, want.status, st));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic        cfg_index = wdtfk_pkg::CFG_FEED_KEY;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = wdtfk_pkg::OP_TICK;
	logic [11:0] offset = '0;
	logic [31:0] write_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] read_data;
	logic        irq;
	logic [1:0]  access_status;

	wdt_scoreboard sb;
	int          idle_cycles = 0;
	bit          moved;
	int          burst_left = 0;
	int          gap_max = 0;
	int          rx_mode = 0;
	int          rx_left = 0;
	logic [15:0] rx_pattern = 16'h0001;
	logic [3:0]  rx_bit = '0;

	watchdog_timer_with_feed_key_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.offset        (offset),
		.write_data    (write_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.read_data     (read_data),
		.irq           (irq),
		.access_status (access_status)
	);

	always #4 clk = ~clk;

	// Receiver: switch at random between always-ready, random stalls and a
	// rotating 16-bit pattern. Bit 0 of the pattern is forced so a patterned
	// stall always ends within one pass through the pattern.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode    = $urandom_range(0, 2);
			rx_pattern = 16'($urandom) | 16'h0001;
			rx_left    = $urandom_range(50, 300);
		end
		rx_left--;
		case (rx_mode)
		0: out_ready = 1'b1;
		1: out_ready = ($urandom_range(0, 3) != 0);
		default: begin
			out_ready = rx_pattern[rx_bit];
			rx_bit    = rx_bit + 1'b1;
		end
		endcase
	end

	// Monitor: both handshakes are sampled at the rising edge, before the
	// block's own registers move. Any handshake clears the hang counter.
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && in_ready) begin
				sb.apply_access(operation, offset, write_data);
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				sb.check_response(read_data, irq, access_status);
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// Hang detector: end the run if nothing moves for too long.
	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// Present one item and hold it until accepted. Between bursts of random
	// length, drop valid for a random gap and randomize the idle payload.
	task automatic send_item(input logic [1:0] op, input logic [11:0] ofs,
			input logic [31:0] data);
		if (gap_max > 0 && burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			repeat ($urandom_range(1, gap_max)) begin
				@(negedge clk);
				in_valid   = 1'b0;
				operation  = 2'($urandom);
				offset     = 12'($urandom);
				write_data = $urandom;
			end
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		in_valid   = 1'b1;
		operation  = op;
		offset     = ofs;
		write_data = data;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Drop valid and hold off until every outstanding response has come back,
	// then let the two-stage pipeline settle.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.due_responses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Key writes only happen with the block drained.
	task automatic set_key(input logic idx, input logic [31:0] value);
		@(negedge clk);
		cfg_write_en = 1'b1;
		cfg_index    = idx;
		cfg_data     = value;
		@(negedge clk);
		cfg_write_en = 1'b0;
		sb.set_key(idx, value);
	endtask

	// Random traffic biased toward sequences that matter: frequent ticks,
	// short LOAD values so the counter actually expires, and KEY writes of
	// which half or more carry the feed key. The lock stays clear unless allowed.
	task automatic run_phase(input int n_items, input bit allow_lock);
		logic [1:0]  op;
		logic [11:0] ofs;
		logic [31:0] data;
		int          pick;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				op = wdtfk_pkg::OP_TICK;
			else if (pick < 65)
				op = wdtfk_pkg::OP_READ;
			else if (pick < 96)
				op = wdtfk_pkg::OP_WRITE;
			else
				op = OP_NOP;
			case ($urandom_range(0, 9))
			0, 1:    ofs = wdtfk_pkg::OFS_CTRL;
			2, 3:    ofs = wdtfk_pkg::OFS_LOAD;
			4:       ofs = wdtfk_pkg::OFS_VAL;
			5:       ofs = wdtfk_pkg::OFS_SR;
			6, 7:    ofs = wdtfk_pkg::OFS_KEY;
			default: ofs = 12'($urandom);
			endcase
			data = $urandom;
			if (op == wdtfk_pkg::OP_WRITE) begin
				case (ofs)
				wdtfk_pkg::OFS_CTRL: data[wdtfk_pkg::CTRL_EN] = ($urandom_range(0, 3) != 0);
				wdtfk_pkg::OFS_LOAD: begin
					if ($urandom_range(0, 3) != 0)
						data = $urandom_range(0, 12);
				end
				wdtfk_pkg::OFS_KEY: begin
					case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: data = sb.feed_key;
					5:             data = sb.lock_key;
					default: ;
					endcase
				end
				default: ;
				endcase
				if (!allow_lock) begin
					if (ofs == wdtfk_pkg::OFS_CTRL)
						data[wdtfk_pkg::CTRL_LOCK] = 1'b0;
					if (ofs == wdtfk_pkg::OFS_KEY && data == sb.lock_key &&
							data != sb.feed_key)
						data = sb.feed_key;
				end
			end
			send_item(op, ofs, data);
		end
	endtask

	initial begin
		logic [31:0] fk;
		logic [31:0] lk;
		sb = new();

		// hold reset, then release it away from the rising edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening, no idling on the sender side.
		gap_max = 0;
		send_item(wdtfk_pkg::OP_READ, wdtfk_pkg::OFS_CTRL, 32'h0);
		send_item(wdtfk_pkg::OP_READ, wdtfk_pkg::OFS_LOAD, 32'h0);
		send_item(wdtfk_pkg::OP_READ, wdtfk_pkg::OFS_VAL, 32'h0);
		send_item(wdtfk_pkg::OP_READ, wdtfk_pkg::OFS_SR, 32'h0);
		// KEY is write only
		send_item(wdtfk_pkg::OP_READ, wdtfk_pkg::OFS_KEY, 32'hFFFF_FFFF);
		send_item(wdtfk_pkg::OP_READ, 12'hFFF, 32'h0);          // top of the offset range
		send_item(wdtfk_pkg::OP_READ, 12'd2, 32'h0);            // unaligned
		send_item(wdtfk_pkg::OP_TICK, 12'hFFF, 32'hFFFF_FFFF);  // tick while disabled
		// disabled: count follows
		send_item(wdtfk_pkg::OP_WRITE, wdtfk_pkg::OFS_LOAD, 32'h0);
		// enable edge, upper bits drop
		send_item(wdtfk_pkg::OP_WRITE, wdtfk_pkg::OFS_CTRL, 32'hFFFF_FFF3);
		send_item(wdtfk_pkg::OP_TICK, 12'h0, 32'h0);            // armed at zero: timeout
		send_item(wdtfk_pkg::OP_TICK, 12'h0, 32'h0);            // disarmed: no effect
		send_item(wdtfk_pkg::OP_READ, wdtfk_pkg::OFS_SR, 32'h0);
		// bit 0 clear: keep timeout
		send_item(wdtfk_pkg::OP_WRITE, wdtfk_pkg::OFS_SR, 32'hFFFF_FFFE);
		send_item(wdtfk_pkg::OP_WRITE, wdtfk_pkg::OFS_SR, 32'h1);
		// enabled: reload only
		send_item(wdtfk_pkg::OP_WRITE, wdtfk_pkg::OFS_LOAD, 32'h2);
		// feed re-arms
		send_item(wdtfk_pkg::OP_WRITE, wdtfk_pkg::OFS_KEY, sb.feed_key);
		send_item(wdtfk_pkg::OP_TICK, 12'h0, 32'h0);
		send_item(wdtfk_pkg::OP_TICK, 12'h0, 32'h0);
		// unknown key
		send_item(wdtfk_pkg::OP_WRITE, wdtfk_pkg::OFS_KEY, 32'hDEAD_BEEF);
		// read-only register
		send_item(wdtfk_pkg::OP_WRITE, wdtfk_pkg::OFS_VAL, 32'h0);
		send_item(wdtfk_pkg::OP_WRITE, 12'hFFF, 32'hFFFF_FFFF); // unmapped write
		send_item(OP_NOP, 12'hFFF, 32'hFFFF_FFFF);
		// disable edge: disarm
		send_item(wdtfk_pkg::OP_WRITE, wdtfk_pkg::OFS_CTRL, 32'h0);
		// feed while disabled
		send_item(wdtfk_pkg::OP_WRITE, wdtfk_pkg::OFS_KEY, sb.feed_key);
		send_item(wdtfk_pkg::OP_READ, wdtfk_pkg::OFS_VAL, 32'h0);

		// Sweep the key registers; every pass starts from a drained block,
		// which also holds the sender off until all responses are back.
		for (int p = 0; p < 6; p++) begin
			drain();
			case (p)
			0: begin fk = 32'h0000_0000; lk = 32'hFFFF_FFFF; end
			1: begin fk = 32'hFFFF_FFFF; lk = 32'h0000_0000; end
			2: begin fk = $urandom; lk = fk; end      // equal keys: feed wins
			4: begin fk = wdtfk_pkg::FEED_KEY_RST; lk = wdtfk_pkg::LOCK_KEY_RST; end
			default: begin fk = $urandom; lk = $urandom; end
			endcase
			set_key(wdtfk_pkg::CFG_FEED_KEY, fk);
			set_key(wdtfk_pkg::CFG_LOCK_KEY, lk);
			case (p % 3)
			0:       gap_max = 0;
			1:       gap_max = 3;
			default: gap_max = 12;
			endcase
			run_phase(150, 1'b0);
		end

		// Last pass: the lock may now be set; it sticks until reset.
		drain();
		set_key(wdtfk_pkg::CFG_FEED_KEY, $urandom);
		set_key(wdtfk_pkg::CFG_LOCK_KEY, $urandom);
		gap_max = 5;
		send_item(wdtfk_pkg::OP_WRITE, wdtfk_pkg::OFS_KEY, sb.lock_key);
		// refused while locked
		send_item(wdtfk_pkg::OP_WRITE, wdtfk_pkg::OFS_CTRL, 32'h0000_0003);
		send_item(wdtfk_pkg::OP_READ, wdtfk_pkg::OFS_CTRL, 32'h0);
		run_phase(125, 1'b1);

		// Wait out the pipeline; the hang detector bounds this.
		drain();
		repeat (8) @(posedge clk);
		if (sb.due_responses.size() != 0)
			sb.note_failure($sformatf("%0d responses never arrived",
				sb.due_responses.size()));
		if (sb.failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/wdtfk_pkg.sv
sv/watchdog_timer_with_feed_key_top.sv
tb/watchdog_timer_with_feed_key_top_tb.sv
